// File: hdl/clb_pkg.sv
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants of the console line edit buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

	localparam int DEFAULT_BUFFER_DEPTH = 128;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_CTRL_D = 8'h04;
	localparam logic [7:0] CH_CTRL_H = 8'h08;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_CTRL_P = 8'h10;
	localparam logic [7:0] CH_CTRL_U = 8'h15;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	localparam logic [2:0] ST_DATA  = 3'd0;
	localparam logic [2:0] ST_LINE  = 3'd1;
	localparam logic [2:0] ST_EOF   = 3'd2;
	localparam logic [2:0] ST_EMPTY = 3'd3;
	localparam logic [2:0] ST_NONE  = 3'd4;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       dump_request;
		logic       dropped;
		logic [7:0] read_byte;
		logic [2:0] read_status;
	} clb_result_t;

	typedef struct packed {
		logic        push;
		clb_result_t result;
	} clb_push_t;

endpackage

// File: hdl/clb_if.sv
// ----------------------------------------------------------------------------
// clb_req_if / clb_rsp_if
// Valid/ready channels for requests into and results out of the block.
// ----------------------------------------------------------------------------
interface clb_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_char;
	logic       read_first;

	modport source (output valid, output opcode, output rx_char, output read_first,
		input ready);
	modport sink (input valid, input opcode, input rx_char, input read_first,
		output ready);
endinterface

interface clb_rsp_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [7:0] echo_char;
	logic [7:0] erase_count;
	logic       dump_request;
	logic       dropped;
	logic [7:0] read_byte;
	logic [2:0] read_status;

	modport source (output valid, output echo_valid, output echo_char,
		output erase_count, output dump_request, output dropped, output read_byte,
		output read_status, input ready);
	modport sink (input valid, input echo_valid, input echo_char, input erase_count,
		input dump_request, input dropped, input read_byte, input read_status,
		output ready);
endinterface

// File: hdl/clb_ram.sv
// ----------------------------------------------------------------------------
// clb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/clb_core.sv
// ----------------------------------------------------------------------------
// clb_core
// Ring indices, line store and per-request edit/read decision logic.
// ----------------------------------------------------------------------------
module clb_core
	import clb_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       opcode,
	input  logic [7:0] rx_char,
	input  logic       read_first,
	output clb_push_t  push
);

	localparam int IW = $clog2(2 * BUFFER_DEPTH);
	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int EW = (IW > 8) ? IW : 9;
	localparam logic [IW-1:0] IDX_MAX = IW'(2 * BUFFER_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_I = IW'(BUFFER_DEPTH);
	localparam logic [IW:0]   MOD_W   = (IW+1)'(2 * BUFFER_DEPTH);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
		return (a == IDX_MAX) ? '0 : a + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
		return (a == '0) ? IDX_MAX : a - IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_diff(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] s;
		s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + MOD_W - {1'b0, b});
		return s[IW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot(input logic [IW-1:0] a);
		logic [IW-1:0] s;
		s = (a >= DEPTH_I) ? (a - DEPTH_I) : a;
		return s[AW-1:0];
	endfunction

	logic [IW-1:0] read_q, commit_q, edit_q;
	logic [IW-1:0] read_d, commit_d, edit_d;
	logic          fwd_q;
	logic [7:0]    fwd_data_q;
	logic [7:0]    ram_rdata, head;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, ch;
	logic [IW-1:0] fill, uncommitted;
	logic [EW-1:0] erase_ext;
	logic          is_rx, is_rd, empty, full;
	clb_result_t   res;

	assign head        = fwd_q ? fwd_data_q : ram_rdata;
	assign fill        = idx_diff(edit_q, read_q);
	assign uncommitted = idx_diff(edit_q, commit_q);
	assign erase_ext   = EW'(uncommitted);
	assign is_rx       = accept && !opcode;
	assign is_rd       = accept && opcode;
	assign empty       = (read_q == commit_q);
	assign full        = (fill >= DEPTH_I);
	assign ch          = (rx_char == CH_CR) ? CH_LF : rx_char;

	always_comb begin
		read_d   = read_q;
		commit_d = commit_q;
		edit_d   = edit_q;
		we       = 1'b0;
		wdata    = ch;
		res      = '0;
		res.read_status = ST_NONE;
		if (is_rx) begin
			priority if (rx_char == CH_CTRL_P) begin
				res.dump_request = 1'b1;
			end else if (rx_char == CH_CTRL_U) begin
				res.erase_count = (erase_ext > EW'(255)) ? 8'hFF : erase_ext[7:0];
				edit_d = commit_q;
			end else if (rx_char == CH_CTRL_H || rx_char == CH_DEL) begin
				if (edit_q != commit_q) begin
					edit_d = idx_dec(edit_q);
					res.erase_count = 8'd1;
				end
			end else if (full) begin
				res.dropped = 1'b1;
			end else begin
				if (rx_char != CH_NUL) begin
					we = 1'b1;
					res.echo_valid = 1'b1;
					res.echo_char  = ch;
					edit_d = idx_inc(edit_q);
					if (ch == CH_LF || ch == CH_CTRL_D ||
						idx_diff(idx_inc(edit_q), read_q) == DEPTH_I) begin
						commit_d = idx_inc(edit_q);
					end
				end
			end
		end else if (is_rd) begin
			if (empty) begin
				res.read_status = ST_EMPTY;
			end else if (head == CH_CTRL_D) begin
				if (read_first) begin
					read_d = idx_inc(read_q);
				end
				res.read_status = ST_EOF;
			end else begin
				read_d = idx_inc(read_q);
				res.read_byte   = head;
				res.read_status = (head == CH_LF) ? ST_LINE : ST_DATA;
			end
		end
	end

	assign waddr = slot(edit_q);
	assign raddr = slot(read_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
			fwd_q    <= 1'b0;
		end else begin
			read_q   <= read_d;
			commit_q <= commit_d;
			edit_q   <= edit_d;
			fwd_q    <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
	end

	clb_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	assign push.push   = accept;
	assign push.result = res;

	a_empty_read_holds: assert property (@(posedge clk) disable iff (!arst_n)
		is_rd && empty |=> $stable(read_q) && $stable(commit_q) && $stable(edit_q))
		else $error("empty read moved an index");

	a_full_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push.result.dropped |=> $stable(edit_q) && $stable(commit_q))
		else $error("dropped character changed the ring");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		is_rx && !full |=> idx_diff(edit_q, read_q) <= DEPTH_I)
		else $error("ring overfilled");

	a_read_no_edit: assert property (@(posedge clk) disable iff (!arst_n)
		is_rd |=> $stable(edit_q) && $stable(commit_q))
		else $error("read request changed edit state");

endmodule

// File: hdl/clb_out_buf.sv
// ----------------------------------------------------------------------------
// clb_out_buf
// Two-entry result queue that decouples the result channel from requests.
// ----------------------------------------------------------------------------
module clb_out_buf
	import clb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  clb_push_t push,
	output logic      ready,
	clb_rsp_if.source rsp_ch
);

	clb_result_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push, do_pop;
	clb_result_t head;

	assign ready   = (count_q != 2'd2);
	assign do_push = push.push && ready;
	assign do_pop  = rsp_ch.valid && rsp_ch.ready;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.result;
		end
	end

	assign rsp_ch.valid        = (count_q != 2'd0);
	assign rsp_ch.echo_valid   = head.echo_valid;
	assign rsp_ch.echo_char    = head.echo_char;
	assign rsp_ch.erase_count  = head.erase_count;
	assign rsp_ch.dump_request = head.dump_request;
	assign rsp_ch.dropped      = head.dropped;
	assign rsp_ch.read_byte    = head.read_byte;
	assign rsp_ch.read_status  = head.read_status;

endmodule

// File: hdl/console_line_edit_buffer.sv
// ----------------------------------------------------------------------------
// console_line_edit_buffer
// Canonical console line editor over a ring of received characters.
//
// req_ch carries one request: opcode 0 hands in a character from the line,
// opcode 1 asks for one committed byte (read_first marks the first byte of
// a read). rsp_ch returns exactly one result per request: echo, erase count,
// dump and drop flags for a character, byte and status for a read.
// A request is taken in the cycle it is presented, and its result is written
// into the result queue; one request per cycle is sustained while that queue
// has room. The decision for a read uses the head byte, which the line store
// prefetches each cycle for the next read index, so no request waits on the
// RAM read port. Results wait in a two-entry queue; while the receiver stalls,
// requests keep being taken until that queue is full, then req_ch.ready drops.
// Reset clears all ring indices, so the ring starts empty; the line store
// itself is not cleared, and only committed, written bytes are read.
// ----------------------------------------------------------------------------
module console_line_edit_buffer
	import clb_pkg::*;
#(
	parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	clb_req_if.sink   req_ch,
	clb_rsp_if.source rsp_ch
);

	clb_push_t push;
	logic      buf_ready;

	assign req_ch.ready = buf_ready;

	clb_core #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (req_ch.valid && buf_ready),
		.opcode     (req_ch.opcode),
		.rx_char    (req_ch.rx_char),
		.read_first (req_ch.read_first),
		.push       (push)
	);

	clb_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.ready  (buf_ready),
		.rsp_ch (rsp_ch)
	);

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the console line edit buffer against a line discipline predictor.
// A table of directed requests covers empty reads, erases with nothing to
// erase, dump, NUL, CR mapping and both kinds of control-D read. A random
// part follows, built from typed lines, read bursts, noise and floods that
// fill the ring. Both channels idle in random bursts. Floods with idling on
// hold the receiver off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import clb_pkg::*;

	localparam int DEPTH = DEFAULT_BUFFER_DEPTH;
	localparam int POS_MOD = 2 * DEPTH;
	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_REQUESTS = 900;
	localparam int QUIET_TAIL = 120;
	localparam int HOLD_OFF_CYCLES = 80;

	localparam logic OP_RX = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  ch;
		logic        first;
		logic        typed;
		clb_result_t res;
	} directed_row_t;

	logic clk;
	logic arst_n;

	clb_req_if req_ch ();
	clb_rsp_if rsp_ch ();

	console_line_edit_buffer #(
		.BUFFER_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch),
		.rsp_ch(rsp_ch)
	);

	logic [7:0] line_copy [DEPTH];
	int read_pos;
	int commit_pos;
	int edit_pos;

	clb_result_t pending_results [$];
	int request_count;
	int mismatch_count;
	bit idle_enable;
	bit hold_off_request;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{OP_READ, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EMPTY}},
		'{OP_RX, CH_CTRL_H, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, CH_CTRL_U, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, CH_CTRL_P, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b1, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, CH_NUL, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, 8'h61, 1'b0, 1'b1, '{1'b1, 8'h61, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, 8'hFF, 1'b1, 1'b1, '{1'b1, 8'hFF, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, CH_DEL, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd1, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, CH_CTRL_H, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd1, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, 8'h80, 1'b0, 1'b0, '0},
		'{OP_RX, 8'h01, 1'b0, 1'b0, '0},
		'{OP_RX, CH_CTRL_U, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd2, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_RX, 8'h68, 1'b0, 1'b0, '0},
		'{OP_RX, CH_CR, 1'b0, 1'b1, '{1'b1, CH_LF, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_READ, 8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h68, ST_DATA}},
		'{OP_READ, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, CH_LF, ST_LINE}},
		'{OP_READ, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EMPTY}},
		'{OP_RX, CH_CTRL_D, 1'b0, 1'b1, '{1'b1, CH_CTRL_D, 8'd0, 1'b0, 1'b0, 8'h00, ST_NONE}},
		'{OP_READ, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EOF}},
		'{OP_READ, 8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EOF}},
		'{OP_READ, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EOF}},
		'{OP_READ, 8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 8'd0, 1'b0, 1'b0, 8'h00, ST_EMPTY}},
		'{OP_RX, CH_LF, 1'b0, 1'b0, '0},
		'{OP_READ, 8'h00, 1'b1, 1'b0, '0}
	};

	function automatic int ring_distance(input int a, input int b);
		return (a + POS_MOD - b) % POS_MOD;
	endfunction

	function automatic clb_result_t line_discipline_result(input logic op, input logic [7:0] ch,
		input logic first);
		clb_result_t r;
		logic [7:0] c;
		logic [7:0] head;
		int erased;
		r = '0;
		r.read_status = ST_NONE;
		c = ch;
		if (op == OP_RX) begin
			if (c == CH_CTRL_P) begin
				r.dump_request = 1'b1;
			end else if (c == CH_CTRL_U) begin
				erased = ring_distance(edit_pos, commit_pos);
				edit_pos = commit_pos;
				r.erase_count = (erased > 255) ? 8'd255 : 8'(erased);
			end else if (c == CH_CTRL_H || c == CH_DEL) begin
				if (edit_pos != commit_pos) begin
					edit_pos = (edit_pos + POS_MOD - 1) % POS_MOD;
					r.erase_count = 8'd1;
				end
			end else if (ring_distance(edit_pos, read_pos) >= DEPTH) begin
				r.dropped = 1'b1;
			end else if (c != CH_NUL) begin
				if (c == CH_CR)
					c = CH_LF;
				r.echo_valid = 1'b1;
				r.echo_char = c;
				line_copy[edit_pos % DEPTH] = c;
				edit_pos = (edit_pos + 1) % POS_MOD;
				if (c == CH_LF || c == CH_CTRL_D || ring_distance(edit_pos, read_pos) == DEPTH)
					commit_pos = edit_pos;
			end
		end else if (read_pos == commit_pos) begin
			r.read_status = ST_EMPTY;
		end else begin
			head = line_copy[read_pos % DEPTH];
			if (head == CH_CTRL_D) begin
				if (first)
					read_pos = (read_pos + 1) % POS_MOD;
				r.read_status = ST_EOF;
			end else begin
				read_pos = (read_pos + 1) % POS_MOD;
				r.read_byte = head;
				r.read_status = (head == CH_LF) ? ST_LINE : ST_DATA;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_line_char();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 62)
			return 8'($urandom_range(8'h20, 8'h7E));
		else if (roll < 72)
			return 8'($urandom_range(0, 255));
		else if (roll < 78)
			return CH_CTRL_H;
		else if (roll < 82)
			return CH_DEL;
		else if (roll < 85)
			return CH_CTRL_U;
		else if (roll < 88)
			return CH_CTRL_P;
		else if (roll < 91)
			return CH_NUL;
		else if (roll < 95)
			return CH_CR;
		else
			return 8'($urandom_range(128, 255));
	endfunction

	task automatic send_request(input logic op, input logic [7:0] ch, input logic first,
		input logic typed, input clb_result_t typed_res);
		clb_result_t predicted;
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.rx_char <= ch;
		req_ch.read_first <= first;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = line_discipline_result(op, ch, first);
		pending_results.push_back(typed ? typed_res : predicted);
		request_count++;
	endtask

	task automatic flood_ring(input int count);
		hold_off_request = idle_enable;
		for (int k = 0; k < count; k++)
			send_request(OP_RX, ($urandom_range(0, 49) == 0) ? CH_NUL :
				8'($urandom_range(8'h21, 8'h7E)), 1'b0, 1'b0, '0);
	endtask

	task automatic read_burst(input int count);
		for (int k = 0; k < count; k++)
			send_request(OP_READ, 8'($urandom), (k == 0) ? 1'b1 : ($urandom_range(0, 7) == 0),
				1'b0, '0);
	endtask

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		int stall;
		clb_result_t got;
		clb_result_t want;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.echo_valid, rsp_ch.echo_char, rsp_ch.erase_count,
					rsp_ch.dump_request, rsp_ch.dropped, rsp_ch.read_byte, rsp_ch.read_status};
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result %h at %0t", got, $realtime);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						if (mismatch_count < 10) begin
							$display("mismatch at %0t: echo %b/%h erase %0d dump %b drop %b read %h/%0d",
								$realtime, want.echo_valid, want.echo_char, want.erase_count,
								want.dump_request, want.dropped, want.read_byte, want.read_status);
							$display("  actual:     echo %b/%h erase %0d dump %b drop %b read %h/%0d",
								got.echo_valid, got.echo_char, got.erase_count, got.dump_request,
								got.dropped, got.read_byte, got.read_status);
						end
						mismatch_count++;
					end
				end
			end
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (stall == 0 && idle_enable && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4);
			end
			if (stall > 0) begin
				stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int len;
		int roll;
		for (int k = 0; k < DEPTH; k++)
			line_copy[k] = 8'h00;
		read_pos = 0;
		commit_pos = 0;
		edit_pos = 0;
		request_count = 0;
		mismatch_count = 0;
		idle_enable = 1'b1;
		hold_off_request = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_RX;
		req_ch.rx_char <= 8'h00;
		req_ch.read_first <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k])
			send_request(directed_rows[k].op, directed_rows[k].ch, directed_rows[k].first,
				directed_rows[k].typed, directed_rows[k].res);

		flood_ring(DEPTH + 6);
		read_burst(DEPTH + 8);

		while (request_count < DIRECTED_ROWS + RANDOM_REQUESTS) begin
			if (request_count >= DIRECTED_ROWS + RANDOM_REQUESTS - QUIET_TAIL)
				idle_enable = 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 44) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
				for (int k = 0; k < len; k++)
					send_request(OP_RX, pick_line_char(), 1'($urandom), 1'b0, '0);
				roll = $urandom_range(0, 99);
				if (roll < 70)
					send_request(OP_RX, roll[0] ? CH_CR : CH_LF, 1'b0, 1'b0, '0);
				else if (roll < 85)
					send_request(OP_RX, CH_CTRL_D, 1'b0, 1'b0, '0);
			end else if (roll < 80) begin
				read_burst($urandom_range(1, 40));
			end else if (roll < 97) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++)
					send_request(1'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
			end else begin
				flood_ring($urandom_range(DEPTH - 8, DEPTH + 12));
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: console_line_edit_buffer.f
hdl/clb_pkg.sv
hdl/clb_if.sv
hdl/clb_ram.sv
hdl/clb_core.sv
hdl/clb_out_buf.sv
hdl/console_line_edit_buffer.sv
test/testbench.sv
